FILE: design/srins_pkg.sv
`default_nettype none

package srins_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] quantity;
        logic        [7:0]  kind;
        logic signed [31:0] expiry;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic load;
        logic rec_valid;
        logic last;
        logic overflow;
    } emit_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_FL_RD,
        ST_FL_OUT,
        ST_FL_EMPTY
    } state_t;

endpackage

`default_nettype wire

FILE: design/srins_ram.sv
`default_nettype none

module srins_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/srins_seq.sv
`default_nettype none

module srins_seq #(
    parameter int CAPACITY = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        in_op,
    input  wire srins_pkg::rec_t             in_rec,
    input  wire logic                        out_free,
    output srins_pkg::emit_t                 emit,
    output srins_pkg::rec_t                  emit_rec,
    output logic                             ram_wr_en,
    output logic [$clog2(CAPACITY)-1:0]      ram_wr_addr,
    output srins_pkg::rec_t                  ram_wr_data,
    output logic                             ram_rd_en,
    output logic [$clog2(CAPACITY)-1:0]      ram_rd_addr,
    input  wire srins_pkg::rec_t             ram_rd_data
);

    import srins_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          flag_reg, flag_next;
    rec_t          new_rec_reg, new_rec_next;

    logic [CW-1:0] idx_dec;
    logic [CW-1:0] idx_inc;
    logic          key_le;
    logic          flush_last;

    assign idx_dec    = idx_reg - CW'(1);
    assign idx_inc    = idx_reg + CW'(1);
    assign key_le     = $signed(ram_rd_data.key) <= $signed(new_rec_reg.key);
    assign flush_last = (idx_inc == count_reg);
    assign in_stall   = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == OP_FLUSH)
                    begin
                        state_next = (count_reg == '0) ? ST_FL_EMPTY : ST_FL_RD;
                    end
                    else if (count_reg != CAP_W)
                    begin
                        state_next = ST_INS_CHK;
                    end
                end
            end
            ST_INS_CHK:
            begin
                state_next = (idx_reg == '0) ? ST_IDLE : ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                state_next = key_le ? ST_IDLE : ST_INS_CHK;
            end
            ST_FL_RD:
            begin
                state_next = ST_FL_OUT;
            end
            ST_FL_OUT:
            begin
                if (out_free)
                begin
                    state_next = flush_last ? ST_IDLE : ST_FL_RD;
                end
            end
            ST_FL_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        flag_next    = flag_reg;
        new_rec_next = new_rec_reg;
        emit         = '0;
        emit_rec     = '0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = idx_reg[AW-1:0];
        ram_wr_data  = new_rec_reg;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = idx_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == OP_FLUSH)
                    begin
                        idx_next = '0;
                    end
                    else if (count_reg == CAP_W)
                    begin
                        flag_next = 1'b1;
                    end
                    else
                    begin
                        new_rec_next = in_rec;
                        idx_next     = count_reg;
                    end
                end
            end
            ST_INS_CHK:
            begin
                if (idx_reg == '0)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = '0;
                    count_next  = count_reg + CW'(1);
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_dec[AW-1:0];
                end
            end
            ST_INS_CMP:
            begin
                // The new request lands right above the first stored key that is not larger.
                ram_wr_en = 1'b1;
                if (key_le)
                begin
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    ram_wr_data = ram_rd_data;
                    idx_next    = idx_dec;
                end
            end
            ST_FL_RD:
            begin
                ram_rd_en = 1'b1;
            end
            ST_FL_OUT:
            begin
                emit_rec = ram_rd_data;
                if (out_free)
                begin
                    emit.load      = 1'b1;
                    emit.rec_valid = 1'b1;
                    emit.last      = flush_last;
                    emit.overflow  = flag_reg;
                    if (flush_last)
                    begin
                        count_next = '0;
                        flag_next  = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end
            ST_FL_EMPTY:
            begin
                if (out_free)
                begin
                    emit.load     = 1'b1;
                    emit.last     = 1'b1;
                    emit.overflow = flag_reg;
                    flag_next     = 1'b0;
                end
            end
            default:
            begin
                emit = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_rec_reg <= new_rec_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_W)
        else $error("entry count exceeds capacity");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (CW'(ram_wr_addr) <= count_reg))
        else $error("store write beyond the filled region");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit.load |-> out_free)
        else $error("result emitted into an occupied output register");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.load && emit.last) |=> (count_reg == '0 && !flag_reg))
        else $error("table not emptied after the last flush result");

endmodule

`default_nettype wire

FILE: design/sorted_record_insertion_core.sv
// An insert request keeps the block busy while it moves each stored record with a larger key
// up by one place; an insert into a full table is dropped and leaves the block idle.
// A flush of a non-empty table reads each record and then gives it as a result, one record
// at a time, in the separate read and output steps of the sequencer; the output step waits
// while a held result is stalled. A flush of an empty table gives a single result.
// Reset clears the sequencer state, the entry count, the overflow flag and the result valid
// flag; the record store is not cleared and needs no clearing pass.
`default_nettype none

module sorted_record_insertion_core #(
    parameter int CAPACITY = srins_pkg::DEF_CAPACITY
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               op,
    input  wire logic signed [31:0] rec_key,
    input  wire logic signed [31:0] rec_quantity,
    input  wire logic        [7:0]  rec_kind,
    input  wire logic signed [31:0] rec_expiry,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic signed [31:0]      out_key,
    output logic signed [31:0]      out_quantity,
    output logic        [7:0]       out_kind,
    output logic signed [31:0]      out_expiry,
    output logic                    out_valid,
    output logic                    out_last,
    output logic                    out_overflow
);

    import srins_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    rec_t          in_rec;
    emit_t         emit;
    rec_t          emit_rec;
    logic          out_free;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    rec_t          ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    rec_t          ram_rd_data;

    logic          res_valid_reg, res_valid_next;
    rec_t          res_rec_reg;
    logic          res_flag_valid_reg;
    logic          res_last_reg;
    logic          res_overflow_reg;

    assign in_rec.key      = rec_key;
    assign in_rec.quantity = rec_quantity;
    assign in_rec.kind     = rec_kind;
    assign in_rec.expiry   = rec_expiry;

    assign out_free = !res_valid_reg || !res_stall;

    srins_seq #(
        .CAPACITY(CAPACITY)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_op      (op),
        .in_rec     (in_rec),
        .out_free   (out_free),
        .emit       (emit),
        .emit_rec   (emit_rec),
        .ram_wr_en  (ram_wr_en),
        .ram_wr_addr(ram_wr_addr),
        .ram_wr_data(ram_wr_data),
        .ram_rd_en  (ram_rd_en),
        .ram_rd_addr(ram_rd_addr),
        .ram_rd_data(ram_rd_data)
    );

    srins_ram #(
        .WIDTH(REC_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    always_comb
    begin
        priority if (emit.load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            res_rec_reg        <= emit_rec;
            res_flag_valid_reg <= emit.rec_valid;
            res_last_reg       <= emit.last;
            res_overflow_reg   <= emit.overflow;
        end
    end

    assign res_valid    = res_valid_reg;
    assign out_key      = res_rec_reg.key;
    assign out_quantity = res_rec_reg.quantity;
    assign out_kind     = res_rec_reg.kind;
    assign out_expiry   = res_rec_reg.expiry;
    assign out_valid    = res_flag_valid_reg;
    assign out_last     = res_last_reg;
    assign out_overflow = res_overflow_reg;

endmodule

`default_nettype wire
